// ----- rtl/status_led_fade_blink_assert.svh -----
// assertion macros for the status led controller
`ifndef STATUS_LED_FADE_BLINK_ASSERT_SVH
`define STATUS_LED_FADE_BLINK_ASSERT_SVH
`ifndef SYNTHESIS
`define SLFB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SLFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SLFB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SLFB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/slfb_pkg.sv -----
// shared types, constants and status table for the status led controller
package slfb_pkg;
   localparam int STATUS_COUNT = 8;
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_STATUS = 3'd1;
   localparam logic [2:0] OP_RAW    = 3'd2;
   localparam logic [2:0] OP_OFF    = 3'd3;
   localparam logic [2:0] OP_ACT    = 3'd4;

   localparam logic [2:0] CSR_SCALE_R  = 3'd0;
   localparam logic [2:0] CSR_SCALE_G  = 3'd1;
   localparam logic [2:0] CSR_SCALE_B  = 3'd2;
   localparam logic [2:0] CSR_FADE_DEF = 3'd3;
   localparam logic [2:0] CSR_FADE_OFF = 3'd4;
   localparam logic [2:0] CSR_AUTO_OFF = 3'd5;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] half;
      logic        auto_off;
   } prof_type;

   function automatic prof_type prof_lookup(input logic [2:0] code);
      prof_type p;
      begin
         unique case (code)
            3'd0:    p = '{8'd0,   8'd0,   8'd0,   16'd0,    1'b0};
            3'd1:    p = '{8'd0,   8'd0,   8'd255, 16'd400,  1'b0};
            3'd2:    p = '{8'd0,   8'd0,   8'd255, 16'd0,    1'b0};
            3'd3:    p = '{8'd0,   8'd0,   8'd255, 16'd250,  1'b0};
            3'd4:    p = '{8'd0,   8'd255, 8'd0,   16'd0,    1'b1};
            3'd5:    p = '{8'd255, 8'd0,   8'd0,   16'd1000, 1'b0};
            3'd6:    p = '{8'd255, 8'd0,   8'd0,   16'd150,  1'b1};
            default: p = '{8'd255, 8'd70,  8'd0,   16'd600,  1'b1};
         endcase
         return p;
      end
   endfunction

   // divider job: q = num / den, bit-serial restoring
   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [15:0] den;
   } div_req_type;
endpackage

// ----- rtl/slfb_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module slfb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  slfb_pkg::div_req_type req,
   output logic                 busy,
   output logic [31:0]          quot
);
   import slfb_pkg::*;
`include "status_led_fade_blink_assert.svh"

   logic [31:0] q_ff, q_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [16:0] trial;
   logic [16:0] sub;

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff[15:0], q_ff[31]};
      sub    = trial - {1'b0, den_ff};
      if (req.start) begin
         q_in   = req.num;
         rem_in = '0;
         den_in = req.den;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         if (!sub[16]) begin
            rem_in = sub;
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign busy = (cnt_ff != 6'd0);
   assign quot = q_ff;

   `SLFB_ASSERT_NEXT(a_div_load, clock, reset, req.start, cnt_ff == 6'd32)
   `SLFB_ASSERT_IMPL(a_div_range, clock, reset, 1'b1, cnt_ff <= 6'd32)
   `SLFB_ASSERT_NEXT(a_div_count, clock, reset, busy && !req.start, cnt_ff == $past(cnt_ff) - 6'd1)
endmodule

// ----- rtl/status_led_fade_blink.sv -----
// status led controller top level: command decode, fade, blink and duty scaling
// every word runs three serial divisions by 255 for the duties
// a tick inside a fade first runs three serial fade divisions
// rsp_tvalid rises from ST_OUT once the third duty division is stored
// next word taken only after ST_OUT; a held result stalls only the last step
// synchronous active-high reset restores control and state registers to their reset values
module status_led_fade_blink (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // op[2:0], status_code[5:3], raw_red[13:6],
                                   // raw_green[21:14], raw_blue[29:22], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // duty_red[7:0], duty_green[15:8], duty_blue[23:16],
                                   // current_status[26:24], fading_flag[27],
                                   // blinking_flag[28], zeros
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import slfb_pkg::*;
`include "status_led_fade_blink_assert.svh"

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FADE  = 3'd1;
   localparam logic [2:0] ST_FWAIT = 3'd2;
   localparam logic [2:0] ST_DUTY  = 3'd3;
   localparam logic [2:0] ST_DWAIT = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic [1:0]  ch_ff, ch_in;
   logic [7:0]  scale_ff [3];
   logic [15:0] fdef_ff, foff_ff;
   logic [23:0] aoff_ff;
   logic [31:0] now_ff;
   logic [2:0]  status_ff;
   logic [7:0]  cur_ff [3];
   logic [7:0]  org_ff [3];
   logic [7:0]  tgt_ff [3];
   logic        fade_ff, blink_ff, bon_ff, aoe_ff, fto_ff, ovr_ff;
   logic [31:0] fstart_ff, ltog_ff, lact_ff;
   logic [15:0] flen_ff, half_ff;
   logic [31:0] el_ff;
   logic [7:0]  duty_ff [3];
   logic        rv_ff;
   logic [31:0] rdata_ff;

   div_req_type dreq;
   logic        dbusy;
   logic [31:0] dquot;

   slfb_div u_div (.clock(clock), .reset(reset), .req(dreq), .busy(dbusy), .quot(dquot));

   logic [2:0] op;
   logic [2:0] code;
   logic [7:0] rawc [3];
   assign op      = req_tdata[2:0];
   assign code    = req_tdata[5:3];
   assign rawc[0] = req_tdata[13:6];
   assign rawc[1] = req_tdata[21:14];
   assign rawc[2] = req_tdata[29:22];

   assign req_tready = (st_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   logic acc;
   assign acc = req_tvalid && req_tready;

   // fade magnitude for the channel being worked
   logic [7:0] mag;
   logic       up;
   assign up  = tgt_ff[ch_ff] >= org_ff[ch_ff];
   assign mag = up ? tgt_ff[ch_ff] - org_ff[ch_ff] : org_ff[ch_ff] - tgt_ff[ch_ff];

   always_comb begin
      dreq = '0;
      if (st_ff == ST_FADE) begin
         dreq.start = 1'b1;
         dreq.num   = {24'd0, mag} * el_ff;
         dreq.den   = flen_ff;
      end else if (st_ff == ST_DUTY) begin
         dreq.start = 1'b1;
         dreq.num   = {16'd0, {8'd0, cur_ff[ch_ff]} * {8'd0, scale_ff[ch_ff]}};
         dreq.den   = 16'd255;
      end
   end

   always_ff @(posedge clock) begin
      prof_type p;
      logic [31:0] t;
      logic [15:0] fl;
      logic        do_apply, do_raw;
      logic [2:0]  nstat;
      logic [7:0]  rc [3];
      p = '0; t = now_ff; fl = flen_ff;
      do_apply = 1'b0; do_raw = 1'b0; nstat = status_ff;
      rc[0] = rawc[0]; rc[1] = rawc[1]; rc[2] = rawc[2];
      if (reset) begin
         st_ff <= ST_IDLE; ch_ff <= '0; rv_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            scale_ff[i] <= 8'd255; cur_ff[i] <= '0; org_ff[i] <= '0; tgt_ff[i] <= '0;
         end
         fdef_ff <= 16'd350; foff_ff <= 16'd1000; aoff_ff <= 24'd30000;
         now_ff <= '0; status_ff <= '0; fade_ff <= 1'b0; fstart_ff <= '0;
         flen_ff <= 16'd350; blink_ff <= 1'b0; bon_ff <= 1'b0; half_ff <= 16'd500;
         ltog_ff <= '0; lact_ff <= '0; aoe_ff <= 1'b0; fto_ff <= 1'b0; ovr_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SCALE_R:  scale_ff[0] <= csr_data[7:0];
               CSR_SCALE_G:  scale_ff[1] <= csr_data[7:0];
               CSR_SCALE_B:  scale_ff[2] <= csr_data[7:0];
               CSR_FADE_DEF: fdef_ff <= csr_data[15:0];
               CSR_FADE_OFF: foff_ff <= csr_data[15:0];
               CSR_AUTO_OFF: aoff_ff <= csr_data;
               default: ;
            endcase
         end
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: begin
               if (acc) begin
                  st_ff <= ST_DUTY; ch_ff <= '0;
                  case (op)
                     OP_TICK: begin
                        logic bl, fa, ft, bo;
                        logic [7:0] tg [3];
                        logic [7:0] cu [3];
                        logic [7:0] og [3];
                        logic [31:0] fst;
                        t = now_ff + 32'd1;
                        bl = blink_ff; fa = fade_ff; ft = fto_ff; bo = bon_ff;
                        fst = fstart_ff;
                        for (int i = 0; i < 3; i++) begin
                           tg[i] = tgt_ff[i]; cu[i] = cur_ff[i]; og[i] = org_ff[i];
                        end
                        now_ff <= t;
                        if (aoe_ff && !fto_ff && !ovr_ff
                            && (t - lact_ff) >= {8'd0, aoff_ff}) begin
                           bl = 1'b0; bo = 1'b0;
                           for (int i = 0; i < 3; i++) begin
                              tg[i] = '0; og[i] = cu[i];
                           end
                           ft = 1'b1; fa = 1'b1; fst = t; fl = foff_ff;
                        end
                        if (bl) begin
                           if ((t - ltog_ff) >= {16'd0, half_ff}) begin
                              ltog_ff <= t;
                              bo = !bo;
                              for (int i = 0; i < 3; i++) cu[i] = bo ? tg[i] : 8'd0;
                           end
                        end else if (fa) begin
                           if ((t - fst) >= {16'd0, fl}) begin
                              for (int i = 0; i < 3; i++) cu[i] = tg[i];
                              fa = 1'b0;
                              if (ft) begin
                                 ft = 1'b0; ovr_ff <= 1'b1;
                              end
                           end else begin
                              st_ff <= ST_FADE;
                              el_ff <= t - fst;
                           end
                        end
                        blink_ff <= bl; fade_ff <= fa; fto_ff <= ft; bon_ff <= bo;
                        fstart_ff <= fst; flen_ff <= fl;
                        for (int i = 0; i < 3; i++) begin
                           tgt_ff[i] <= tg[i]; cur_ff[i] <= cu[i]; org_ff[i] <= og[i];
                        end
                     end
                     OP_STATUS: begin
                        lact_ff <= now_ff;
                        if (status_ff != code) begin
                           nstat = code; do_apply = 1'b1;
                        end else if (fto_ff || ovr_ff) begin
                           do_apply = 1'b1;
                        end
                     end
                     OP_RAW: do_raw = 1'b1;
                     OP_OFF: begin
                        do_raw = 1'b1; nstat = '0;
                        for (int i = 0; i < 3; i++) rc[i] = '0;
                     end
                     OP_ACT: begin
                        lact_ff <= now_ff;
                        if (fto_ff || ovr_ff) do_apply = 1'b1;
                     end
                     default: ;
                  endcase
                  status_ff <= nstat;
                  if (do_raw) begin
                     blink_ff <= 1'b0; bon_ff <= 1'b0; fade_ff <= 1'b0;
                     aoe_ff <= 1'b0; fto_ff <= 1'b0; ovr_ff <= 1'b1;
                     lact_ff <= now_ff;
                     for (int i = 0; i < 3; i++) begin
                        tgt_ff[i] <= rc[i]; cur_ff[i] <= rc[i];
                     end
                  end
                  if (do_apply) begin
                     p = prof_lookup(nstat);
                     tgt_ff[0] <= p.red; tgt_ff[1] <= p.green; tgt_ff[2] <= p.blue;
                     aoe_ff <= p.auto_off; fto_ff <= 1'b0; ovr_ff <= 1'b0;
                     if (p.half != 16'd0) begin
                        blink_ff <= 1'b1; fade_ff <= 1'b0; half_ff <= p.half;
                        ltog_ff <= now_ff; bon_ff <= 1'b1;
                        cur_ff[0] <= p.red; cur_ff[1] <= p.green; cur_ff[2] <= p.blue;
                     end else begin
                        blink_ff <= 1'b0; bon_ff <= 1'b0;
                        for (int i = 0; i < 3; i++) org_ff[i] <= cur_ff[i];
                        fade_ff <= 1'b1; fstart_ff <= now_ff; flen_ff <= fdef_ff;
                     end
                  end
               end
            end
            ST_FADE: st_ff <= ST_FWAIT;
            ST_FWAIT: begin
               if (!dbusy) begin
                  cur_ff[ch_ff] <= up ? org_ff[ch_ff] + dquot[7:0]
                                      : org_ff[ch_ff] - dquot[7:0];
                  if (ch_ff == 2'd2) begin
                     st_ff <= ST_DUTY; ch_ff <= '0;
                  end else begin
                     st_ff <= ST_FADE; ch_ff <= ch_ff + 2'd1;
                  end
               end
            end
            ST_DUTY: st_ff <= ST_DWAIT;
            ST_DWAIT: begin
               if (!dbusy) begin
                  duty_ff[ch_ff] <= dquot[7:0];
                  if (ch_ff == 2'd2) st_ff <= ST_OUT;
                  else begin
                     st_ff <= ST_DUTY; ch_ff <= ch_ff + 2'd1;
                  end
               end
            end
            ST_OUT: begin
               // wait here while the previous word is still held
               if (!rv_ff || rsp_tready) begin
                  rv_ff <= 1'b1; st_ff <= ST_IDLE;
                  rdata_ff <= {3'd0, blink_ff, fade_ff, status_ff,
                               duty_ff[2], duty_ff[1], duty_ff[0]};
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rdata_ff;

   `SLFB_ASSERT_IMPL(a_no_accept_busy, clock, reset, st_ff != ST_IDLE, !req_tready)
   `SLFB_ASSERT_NEXT(a_out_valid, clock, reset, st_ff == ST_OUT, rv_ff)
   `SLFB_ASSERT_IMPL(a_blink_fade, clock, reset, blink_ff, !fade_ff)
   `SLFB_ASSERT_NEXT(a_acc_leaves, clock, reset, acc, st_ff != ST_IDLE)
endmodule

// ----- verif/status_led_fade_blink_tb.sv -----
// self-checking testbench for the status led controller: directed and random commands
`timescale 1ns / 1ps

module status_led_fade_blink_tb;
   import slfb_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [7:0] duty_r;
      logic [7:0] duty_g;
      logic [7:0] duty_b;
      logic [2:0] status;
      logic       fading;
      logic       blinking;
   } led_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   status_led_fade_blink dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   led_result_type pending_duty[$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int cycle_count = 0;
   bit stall_req = 0;
   bit quiet = 0;

   // shadow of the controller state
   logic [7:0]  scl [3];
   logic [15:0] fade_def, fade_off;
   logic [23:0] auto_off;
   logic [31:0] led_time, fade_t0, toggle_t, act_t;
   logic [2:0]  led_status;
   logic [7:0]  cur_col [3];
   logic [7:0]  org_col [3];
   logic [7:0]  tgt_col [3];
   logic [15:0] fade_len, blink_half;
   logic        fade_on, blink_en, blink_lit, autooff_en, off_fade, override_on;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void model_reset();
      for (int i = 0; i < 3; i++) begin
         scl[i] = 8'd255; cur_col[i] = 0; org_col[i] = 0; tgt_col[i] = 0;
      end
      fade_def = 16'd350; fade_off = 16'd1000; auto_off = 24'd30000;
      led_time = 0; led_status = 0; fade_on = 0; fade_t0 = 0; fade_len = 16'd350;
      blink_en = 0; blink_lit = 0; blink_half = 16'd500; toggle_t = 0; act_t = 0;
      autooff_en = 0; off_fade = 0; override_on = 0;
   endfunction

   function automatic logic [7:0] lerp(logic [7:0] from, logic [7:0] to,
                                       logic [31:0] el, logic [15:0] len);
      logic [31:0] mag, q;
      if (len == 0 || el >= {16'd0, len}) return to;
      mag = (to >= from) ? {24'd0, to - from} : {24'd0, from - to};
      q = mag * el / {16'd0, len};
      return (to >= from) ? from + q[7:0] : from - q[7:0];
   endfunction

   function automatic void start_fade(logic [15:0] len);
      for (int i = 0; i < 3; i++) org_col[i] = cur_col[i];
      fade_on = 1; fade_t0 = led_time; fade_len = len;
   endfunction

   function automatic void enter_status();
      logic [23:0] col;
      logic [15:0] half;
      logic        aoff;
      case (led_status)
         3'd0:    begin col = 24'h000000; half = 16'd0;    aoff = 0; end
         3'd1:    begin col = 24'h0000ff; half = 16'd400;  aoff = 0; end
         3'd2:    begin col = 24'h0000ff; half = 16'd0;    aoff = 0; end
         3'd3:    begin col = 24'h0000ff; half = 16'd250;  aoff = 0; end
         3'd4:    begin col = 24'h00ff00; half = 16'd0;    aoff = 1; end
         3'd5:    begin col = 24'hff0000; half = 16'd1000; aoff = 0; end
         3'd6:    begin col = 24'hff0000; half = 16'd150;  aoff = 1; end
         default: begin col = 24'hff4600; half = 16'd600;  aoff = 1; end
      endcase
      tgt_col[0] = col[23:16]; tgt_col[1] = col[15:8]; tgt_col[2] = col[7:0];
      autooff_en = aoff; off_fade = 0; override_on = 0;
      if (half != 0) begin
         blink_en = 1; fade_on = 0; blink_half = half; toggle_t = led_time; blink_lit = 1;
         for (int i = 0; i < 3; i++) cur_col[i] = tgt_col[i];
      end else begin
         blink_en = 0; blink_lit = 0;
         start_fade(fade_def);
      end
   endfunction

   function automatic void load_raw(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      blink_en = 0; blink_lit = 0; fade_on = 0; autooff_en = 0; off_fade = 0;
      override_on = 1;
      tgt_col[0] = r; tgt_col[1] = g; tgt_col[2] = b;
      cur_col[0] = r; cur_col[1] = g; cur_col[2] = b;
      act_t = led_time;
   endfunction

   function automatic void tick_update();
      logic [31:0] el;
      if (autooff_en && !off_fade && !override_on && (led_time - act_t) >= {8'd0, auto_off})
      begin
         blink_en = 0; blink_lit = 0;
         for (int i = 0; i < 3; i++) tgt_col[i] = 0;
         off_fade = 1;
         start_fade(fade_off);
      end
      if (blink_en) begin
         if ((led_time - toggle_t) >= {16'd0, blink_half}) begin
            toggle_t = led_time;
            blink_lit = !blink_lit;
            for (int i = 0; i < 3; i++) cur_col[i] = blink_lit ? tgt_col[i] : 8'd0;
         end
      end else if (fade_on) begin
         el = led_time - fade_t0;
         if (el >= {16'd0, fade_len}) begin
            for (int i = 0; i < 3; i++) cur_col[i] = tgt_col[i];
            fade_on = 0;
            if (off_fade) begin
               off_fade = 0; override_on = 1;
            end
         end else begin
            for (int i = 0; i < 3; i++) cur_col[i] = lerp(org_col[i], tgt_col[i], el, fade_len);
         end
      end
   endfunction

   function automatic led_result_type predict_duty(logic [31:0] word);
      logic [2:0]  op;
      logic [2:0]  code;
      logic [15:0] prod;
      led_result_type res;
      op = word[2:0];
      code = word[5:3];
      case (op)
         OP_TICK: begin
            led_time = led_time + 1;
            tick_update();
         end
         OP_STATUS: begin
            if (code < STATUS_COUNT) begin
               act_t = led_time;
               if (led_status == code) begin
                  if (off_fade || override_on) enter_status();
               end else begin
                  led_status = code;
                  enter_status();
               end
            end
         end
         OP_RAW: load_raw(word[13:6], word[21:14], word[29:22]);
         OP_OFF: begin
            load_raw(0, 0, 0);
            led_status = 0;
         end
         OP_ACT: begin
            act_t = led_time;
            if (off_fade || override_on) enter_status();
         end
         default: ;
      endcase
      prod = {8'd0, cur_col[0]} * {8'd0, scl[0]}; res.duty_r = 8'(prod / 16'd255);
      prod = {8'd0, cur_col[1]} * {8'd0, scl[1]}; res.duty_g = 8'(prod / 16'd255);
      prod = {8'd0, cur_col[2]} * {8'd0, scl[2]}; res.duty_b = 8'(prod / 16'd255);
      res.status = led_status;
      res.fading = fade_on;
      res.blinking = blink_en;
      return res;
   endfunction

   function automatic int gap_len();
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   task automatic send_word(logic [2:0] op, logic [2:0] code = 0,
                            logic [7:0] r = 0, logic [7:0] g = 0, logic [7:0] b = 0,
                            bit no_gap = 0);
      int n;
      @(negedge clock);
      req_tdata <= {2'b00, b, g, r, code, op};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      pending_duty.push_back(predict_duty({2'b00, b, g, r, code, op}));
      words_sent++;
      n = no_gap ? 0 : gap_len();
      // drop valid so the accepted word is never offered twice
      @(negedge clock);
      req_tvalid <= 0;
      if (n > 1) repeat (n - 1) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [23:0] val);
      wait (pending_duty.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      req_tvalid <= 0;
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SCALE_R:  scl[0] = val[7:0];
         CSR_SCALE_G:  scl[1] = val[7:0];
         CSR_SCALE_B:  scl[2] = val[7:0];
         CSR_FADE_DEF: fade_def = val[15:0];
         CSR_FADE_OFF: fade_off = val[15:0];
         CSR_AUTO_OFF: auto_off = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic apply_settings(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                                 logic [15:0] fd, logic [15:0] fo, logic [23:0] ao);
      csr_write(CSR_SCALE_R, {16'd0, sr});
      csr_write(CSR_SCALE_G, {16'd0, sg});
      csr_write(CSR_SCALE_B, {16'd0, sb});
      csr_write(CSR_FADE_DEF, {8'd0, fd});
      csr_write(CSR_FADE_OFF, {8'd0, fo});
      csr_write(CSR_AUTO_OFF, ao);
   endtask

   task automatic send_random_word(bit no_gap = 0);
      int p;
      logic [2:0] op;
      p = $urandom_range(0, 99);
      if (p < 58) op = OP_TICK;
      else if (p < 75) op = OP_STATUS;
      else if (p < 84) op = OP_RAW;
      else if (p < 88) op = OP_OFF;
      else if (p < 95) op = OP_ACT;
      else op = 3'($urandom_range(5, 7));
      send_word(op, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), no_gap);
   endtask

   task automatic test_directed();
      send_word(OP_TICK);
      for (int s = 0; s < STATUS_COUNT; s++) begin
         send_word(OP_STATUS, 3'(s));
         send_word(OP_TICK);
      end
      send_word(OP_RAW, 0, 8'hff, 8'hff, 8'hff);
      send_word(OP_STATUS, 3'd7);       // same status revives after raw override
      send_word(OP_RAW, 0, 8'h00, 8'h00, 8'h00);
      send_word(OP_ACT);
      send_word(OP_OFF, 3'd7, 8'hff, 8'hff, 8'hff);
      send_word(3'd5, 3'd7, 8'hff, 8'hff, 8'hff);
      send_word(3'd6);
      send_word(3'd7, 3'd2);
      // zero fade length and a quick auto-off
      apply_settings(8'd0, 8'd128, 8'd255, 16'd0, 16'd3, 24'd2);
      send_word(OP_STATUS, 3'd4);
      repeat (8) send_word(OP_TICK);
      send_word(OP_STATUS, 3'd4);       // revive after fade to black
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) send_random_word();
   endtask

   task automatic test_backpressure();
      stall_req = 1;
      for (int i = 0; i < 40; i++) send_random_word(1);
      wait (stall_req == 0);
   endtask

   task automatic test_pause();
      test_random(20);
      wait (pending_duty.size() == 0);
      test_random(20);
   endtask

   // result sink with random idling
   initial begin
      int n;
      rsp_tready = 0;
      forever begin
         if (stall_req) begin
            @(negedge clock);
            rsp_tready <= 0;
            repeat (400) @(negedge clock);
            stall_req = 0;
         end
         @(negedge clock);
         rsp_tready <= 1;
         n = gap_len();
         if (n > 0) begin
            @(negedge clock);
            rsp_tready <= 0;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      led_result_type exp_r;
      led_result_type act_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act_r = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[26:24],
                  rsp_tdata[27], rsp_tdata[28]};
         if (pending_duty.size() == 0) begin
            errors++;
            $display("%0t unexpected word: expected none actual %h", $time, rsp_tdata);
         end else begin
            exp_r = pending_duty.pop_front();
            check_field("duty_red", exp_r.duty_r, act_r.duty_r);
            check_field("duty_green", exp_r.duty_g, act_r.duty_g);
            check_field("duty_blue", exp_r.duty_b, act_r.duty_b);
            check_field("current_status", exp_r.status, act_r.status);
            check_field("fading_flag", exp_r.fading, act_r.fading);
            check_field("blinking_flag", exp_r.blinking, act_r.blinking);
            words_checked++;
         end
      end
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      model_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      test_directed();
      apply_settings(8'd255, 8'd255, 8'd255, 16'd12, 16'd8, 24'd40);
      test_random(200);
      quiet = 1;
      test_random(60);
      quiet = 0;
      apply_settings(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 24'd0);
      test_random(120);
      apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                     24'($urandom_range(5, 80)));
      test_backpressure();
      test_pause();
      test_random(180);
      apply_settings(8'd255, 8'd1, 8'd170, 16'd65535, 16'd65535, 24'd16777215);
      test_random(100);

      wait (pending_duty.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d command and tick words, checked %0d results", words_sent,
               words_checked);
      $display("covered every op, all statuses, fades, blinks, auto-off and csr extremes");
      if (errors == 0 && pending_duty.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
